### design/adts_pkg.sv
// Shared types and constants for the ADTS frame deframer.
// No dependencies; used by adts_hdr_decode and adts_frame_deframer.
package adts_pkg;

    // Header sizes in bytes, without and with the CRC word
    localparam int unsigned HDR_BASE = 7;
    localparam int unsigned HDR_CRC  = 9;
    localparam int unsigned HDR_MAX  = HDR_CRC;

    localparam int unsigned CNT_W  = $clog2(HDR_MAX + 1);
    localparam int unsigned FLEN_W = 13;

    // Result kind codes
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef logic [7:0] byte_t;

    // Decoded header fields carried on every result of a frame
    typedef struct packed {
        logic [11:0]       sync_word;
        logic [1:0]        profile;
        logic [3:0]        rate_index;
        logic [2:0]        channel_config;
        logic [FLEN_W-1:0] frame_length;
        logic [10:0]       buffer_fullness;
        logic [1:0]        raw_blocks;
        logic              no_crc;
        logic [15:0]       crc_word;
    } hdr_fields_t;

endpackage

### design/adts_hdr_decode.sv
// Field extraction for one ADTS header (7 bytes, or 9 with CRC).
// Depends on adts_pkg.
module adts_hdr_decode (
    input  adts_pkg::byte_t      hdr_bytes [adts_pkg::HDR_MAX],
    output adts_pkg::hdr_fields_t fields,
    output logic [adts_pkg::CNT_W-1:0] hdr_size
);
    import adts_pkg::*;

    // Slice the header bytes into the fixed bit fields
    always_comb
    begin
        fields.no_crc          = hdr_bytes[1][0];
        fields.sync_word       = {hdr_bytes[0], hdr_bytes[1][7:4]};
        fields.profile         = hdr_bytes[2][7:6];
        fields.rate_index      = hdr_bytes[2][5:2];
        fields.channel_config  = {hdr_bytes[2][0], hdr_bytes[3][7:6]};
        fields.frame_length    = {hdr_bytes[3][1:0], hdr_bytes[4], hdr_bytes[5][7:5]};
        fields.buffer_fullness = {hdr_bytes[5][4:0], hdr_bytes[6][7:2]};
        fields.raw_blocks      = hdr_bytes[6][1:0];
        fields.crc_word        = hdr_bytes[1][0] ? 16'h0000 : {hdr_bytes[7], hdr_bytes[8]};
        hdr_size = hdr_bytes[1][0] ? CNT_W'(HDR_BASE) : CNT_W'(HDR_CRC);
    end

endmodule

### design/adts_frame_deframer.sv
// Top level of the ADTS frame deframer: byte input, header and payload results.
// Depends on adts_pkg and adts_hdr_decode.
//
// Takes one ADTS stream byte per clock unless stalled and produces at most one result per byte.
// Header bytes (7, or 9 when the no-CRC bit is 0) produce no result except the
// last, which yields a header result with the decoded fields; each payload byte
// then yields a payload result repeating those fields, the last one flagged with
// frame_end. A frame_length not larger than the header size flags the header
// result itself as frame end. The sync word is reported, never checked. Throughput
// is one byte per clock while the result side does not stall. A byte accepted is
// held in the input register, and its result is loaded into the result register
// when the byte moves on from there. A stall on the result side backs up into
// in_stall once both registers are full.
module adts_frame_deframer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  adts_pkg::byte_t               stream_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          kind,
    output adts_pkg::byte_t               payload_byte,
    output logic                          frame_end,
    output logic [11:0]                   sync_word,
    output logic [1:0]                    profile,
    output logic [3:0]                    rate_index,
    output logic [2:0]                    channel_config,
    output logic [adts_pkg::FLEN_W-1:0]   frame_length,
    output logic [10:0]                   buffer_fullness,
    output logic [1:0]                    raw_blocks,
    output logic                          no_crc,
    output logic [15:0]                   crc_word
);
    import adts_pkg::*;

    // Input register
    logic        in_valid_reg;
    byte_t       in_byte_reg;

    // Parser state
    logic              in_payload_reg;
    logic [CNT_W-1:0]  header_count_reg;
    byte_t             header_bytes_reg [HDR_MAX];
    logic [FLEN_W-1:0] payload_left_reg;
    hdr_fields_t       held_fields_reg;

    // Result register
    logic        out_valid_reg;
    logic        kind_reg;
    byte_t       payload_byte_reg;
    logic        frame_end_reg;
    hdr_fields_t out_fields_reg;

    // Step logic
    logic              advance;
    byte_t             hdr_view [HDR_MAX];
    hdr_fields_t       dec_fields;
    logic [CNT_W-1:0]  dec_size;
    logic [CNT_W-1:0]  count_inc;
    logic              hdr_done;
    logic [FLEN_W:0]   flen_diff;
    logic              has_payload;
    logic              pay_last;

    // Move the held item on when the result slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    // Header bytes as they stand once the current byte is included
    always_comb
    begin
        for (int i = 0; i < HDR_MAX; i++)
        begin
            hdr_view[i] = (header_count_reg == CNT_W'(i)) ? in_byte_reg : header_bytes_reg[i];
        end
    end

    adts_hdr_decode u_hdr_decode (
        .hdr_bytes (hdr_view),
        .fields    (dec_fields),
        .hdr_size  (dec_size)
    );

    // The header size bit is only looked at once the base header is complete
    assign count_inc   = header_count_reg + CNT_W'(1);
    assign hdr_done    = (count_inc >= CNT_W'(HDR_BASE)) && (count_inc >= dec_size);
    assign flen_diff   = {1'b0, dec_fields.frame_length} - (FLEN_W + 1)'(dec_size);
    assign has_payload = dec_fields.frame_length > FLEN_W'(dec_size);
    assign pay_last    = (payload_left_reg <= FLEN_W'(1));

    // Input register: take a byte whenever the stage is empty or moving on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= stream_byte;
        end
    end

    // Header byte store: write the current byte at the collection position
    always_ff @(posedge clk)
    begin
        if (advance && !in_payload_reg && (header_count_reg < CNT_W'(HDR_MAX)))
        begin
            header_bytes_reg[header_count_reg] <= in_byte_reg;
        end
    end

    // Parser state: count header bytes, then count down the payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg   <= 1'b0;
            header_count_reg <= '0;
            payload_left_reg <= '0;
            held_fields_reg  <= '0;
        end
        else if (advance)
        begin
            if (in_payload_reg)
            begin
                if (pay_last)
                begin
                    in_payload_reg   <= 1'b0;
                    header_count_reg <= '0;
                    payload_left_reg <= '0;
                end
                else
                begin
                    payload_left_reg <= payload_left_reg - FLEN_W'(1);
                end
            end
            else if (hdr_done)
            begin
                held_fields_reg  <= dec_fields;
                header_count_reg <= '0;
                in_payload_reg   <= has_payload;
                payload_left_reg <= has_payload ? flen_diff[FLEN_W-1:0] : '0;
            end
            else
            begin
                header_count_reg <= count_inc;
            end
        end
    end

    // Result valid: set on a result, clear once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= advance && (in_payload_reg || hdr_done);
        end
    end

    // Result payload: load header or payload result
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (in_payload_reg)
            begin
                kind_reg         <= KIND_PAYLOAD;
                payload_byte_reg <= in_byte_reg;
                frame_end_reg    <= pay_last;
                out_fields_reg   <= held_fields_reg;
            end
            else if (hdr_done)
            begin
                kind_reg         <= KIND_HEADER;
                payload_byte_reg <= '0;
                frame_end_reg    <= !has_payload;
                out_fields_reg   <= dec_fields;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign payload_byte    = payload_byte_reg;
    assign frame_end       = frame_end_reg;
    assign sync_word       = out_fields_reg.sync_word;
    assign profile         = out_fields_reg.profile;
    assign rate_index      = out_fields_reg.rate_index;
    assign channel_config  = out_fields_reg.channel_config;
    assign frame_length    = out_fields_reg.frame_length;
    assign buffer_fullness = out_fields_reg.buffer_fullness;
    assign raw_blocks      = out_fields_reg.raw_blocks;
    assign no_crc          = out_fields_reg.no_crc;
    assign crc_word        = out_fields_reg.crc_word;

`ifndef SYNTHESIS
    // Payload phase never runs with a partial header pending
    a_payload_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (header_count_reg == '0))
        else $error("header count nonzero during payload");

    // Payload phase always has bytes left to pass
    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (payload_left_reg != '0))
        else $error("payload phase with nothing left");

    // Header collection never runs past the CRC header size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        header_count_reg < CNT_W'(HDR_MAX))
        else $error("header count out of range");

    // A header result that opens a payload leaves the parser in payload phase
    a_header_opens_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_payload_reg && hdr_done && has_payload) |=> in_payload_reg)
        else $error("payload phase not entered after header");
`endif

endmodule
